### sv/timestamp_stream_merger_defines.svh
// assertion macros for the timestamp stream merger
// used by the top level; expects a clock named clk and a reset named rst
`ifndef TIMESTAMP_STREAM_MERGER_DEFINES_SVH
`define TIMESTAMP_STREAM_MERGER_DEFINES_SVH

// same-cycle implication
`define TSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/tsm_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the timestamp stream merger
// no dependencies
package tsm_pkg;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_CLOSE = 2'd1,
    OP_POP   = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_RECORD = 2'd0,
    ST_WAIT   = 2'd1,
    ST_DONE   = 2'd2,
    ST_ACK    = 2'd3
  } result_t;

  typedef enum logic [1:0] {
    CFG_WINDOW_START = 2'd0,
    CFG_WINDOW_END   = 2'd1,
    CFG_TIME_SELECT  = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    TS_SYSTEM = 2'd0,
    TS_PLANT  = 2'd1,
    TS_LOCAL  = 2'd2,
    TS_ALIAS  = 2'd3
  } time_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP,
    S_PREF_CHK,
    S_CHECK,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_DECIDE,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [63:0] sys_stamp;
    logic [63:0] plant_stamp;
    logic [63:0] loc_stamp;
    logic [63:0] value;
    logic [31:0] flags;
  } rec_t;

  // controller to datapath
  typedef struct packed {
    logic    push;
    logic    close;
    logic    rd_served;
    logic    rd_scan;
    logic    scan_clr;
    logic    scan_cmp;
    logic    scan_next;
    logic    take_pref;
    logic    emit;
    logic    set_done;
    logic    load_res;
    result_t res_kind;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;
    logic pref_avail;
    logic pref_match;
    logic open_empty;
    logic any_data;
    logic past_end;
    logic scan_last;
    logic out_free;
  } stat_t;

  // selected stamp; the unused code acts as the system stamp
  function automatic logic [63:0] pick_time(input time_sel_t sel, input rec_t r);
    logic [63:0] t;
    case (sel)
      TS_PLANT: t = r.plant_stamp;
      TS_LOCAL: t = r.loc_stamp;
      default:  t = r.sys_stamp;
    endcase
    return t;
  endfunction

endpackage

### sv/tsm_ctrl.sv
`timescale 1ns / 1ps
// controller for the timestamp stream merger: sequences push, close and pop
// depends on tsm_pkg
module tsm_ctrl import tsm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_accept,
  input  opcode_t opcode,
  input  stat_t   stat,
  output logic    idle,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_accept && opcode == OP_POP) state_next = S_POP;
      end
      S_POP: begin
        if (stat.done) begin
          if (stat.out_free) state_next = S_IDLE;
        end else if (stat.pref_avail) begin
          state_next = S_PREF_CHK;
        end else begin
          state_next = S_CHECK;
        end
      end
      S_PREF_CHK: begin
        state_next = stat.pref_match ? S_EMIT : S_CHECK;
      end
      S_CHECK: begin
        if (stat.open_empty) begin
          if (stat.out_free) state_next = S_IDLE;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: state_next = S_SCAN_CMP;
      S_SCAN_CMP: begin
        state_next = stat.scan_last ? S_DECIDE : S_SCAN_RD;
      end
      S_DECIDE: begin
        if (!stat.any_data || stat.past_end) begin
          if (stat.out_free) state_next = S_IDLE;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    idle = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          case (opcode)
            OP_PUSH: begin
              cmd.push     = 1'b1;
              cmd.load_res = 1'b1;
              cmd.res_kind = ST_ACK;
            end
            OP_CLOSE: begin
              cmd.close    = 1'b1;
              cmd.load_res = 1'b1;
              cmd.res_kind = ST_ACK;
            end
            OP_POP: ;
            default: begin
              cmd.load_res = 1'b1;
              cmd.res_kind = ST_ACK;
            end
          endcase
        end
      end
      S_POP: begin
        if (stat.done) begin
          cmd.load_res = stat.out_free;
          cmd.res_kind = ST_DONE;
        end else if (stat.pref_avail) begin
          cmd.rd_served = 1'b1;
        end
      end
      S_PREF_CHK: begin
        cmd.take_pref = stat.pref_match;
      end
      S_CHECK: begin
        if (stat.open_empty) begin
          cmd.load_res = stat.out_free;
          cmd.res_kind = ST_WAIT;
        end else begin
          cmd.scan_clr = 1'b1;
        end
      end
      S_SCAN_RD: cmd.rd_scan = 1'b1;
      S_SCAN_CMP: begin
        cmd.scan_cmp  = 1'b1;
        cmd.scan_next = !stat.scan_last;
      end
      S_DECIDE: begin
        if (!stat.any_data || stat.past_end) begin
          cmd.load_res = stat.out_free;
          cmd.set_done = stat.out_free;
          cmd.res_kind = ST_DONE;
        end
      end
      S_EMIT: cmd.emit = stat.out_free;
      default: ;
    endcase
  end

endmodule

### sv/tsm_datapath.sv
`timescale 1ns / 1ps
// datapath for the timestamp stream merger: lane fifos, scan, output register
// depends on tsm_pkg
module tsm_datapath import tsm_pkg::*; #(
  parameter int LANES      = 8,
  parameter int LANE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic        cfg_we,
  input  cfg_index_t  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic [2:0]  lane,
  input  rec_t        in_rec,
  input  logic        corrupt,
  input  logic        out_stall,
  output logic        out_valid,
  output result_t     status,
  output logic [2:0]  out_lane,
  output rec_t        out_rec
);

  localparam int LIW   = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int HW    = $clog2(LANE_DEPTH);
  localparam int FW    = $clog2(LANE_DEPTH + 1);
  localparam int ADDRS = LANES * LANE_DEPTH;
  localparam int AW    = $clog2(ADDRS);

  logic [63:0] window_start;
  logic [63:0] window_end;
  time_sel_t   time_select;

  logic [HW-1:0]  lane_head   [LANES];
  logic [FW-1:0]  lane_fill   [LANES];
  logic [LANES-1:0] lane_closed;

  logic           done;
  logic           served_valid;
  logic [LIW-1:0] served_lane;
  logic [63:0]    served_time;

  logic [LIW-1:0] scan_idx;
  logic           found;
  rec_t           best_rec;
  logic [LIW-1:0] best_lane;

  rec_t           mem [ADDRS];
  rec_t           rd_q;
  logic [AW-1:0]  rd_addr;
  logic [AW-1:0]  wr_addr;
  logic [LIW-1:0] rd_lane;
  logic [LIW-1:0] push_lane;
  logic           lane_ok;
  logic           push_ok;
  logic [FW:0]    wsum;
  logic [HW-1:0]  wslot;
  logic           out_free;
  logic [63:0]    best_time;

  assign push_lane = LIW'(lane);
  assign lane_ok   = (int'(lane) < LANES);
  assign out_free  = !out_valid || !out_stall;
  assign best_time = pick_time(time_select, best_rec);

  // write slot is (head + fill) mod depth, the sum stays below twice the depth
  always_comb begin
    wsum = (FW+1)'(lane_head[push_lane]) + (FW+1)'(lane_fill[push_lane]);
    if (wsum >= (FW+1)'(LANE_DEPTH)) begin
      wsum = wsum - (FW+1)'(LANE_DEPTH);
    end
    wslot   = HW'(wsum);
    wr_addr = AW'(push_lane) * AW'(LANE_DEPTH) + AW'(wslot);
  end

  assign push_ok = lane_ok && !lane_closed[push_lane] && !done && !corrupt
                && (lane_fill[push_lane] != FW'(LANE_DEPTH))
                && !($signed(pick_time(time_select, in_rec)) < $signed(window_start));

  assign rd_lane = cmd.rd_served ? served_lane : scan_idx;
  assign rd_addr = AW'(rd_lane) * AW'(LANE_DEPTH) + AW'(lane_head[rd_lane]);

  always_comb begin
    stat            = '0;
    stat.done       = done;
    stat.pref_avail = served_valid && (lane_fill[served_lane] != '0);
    stat.pref_match = (pick_time(time_select, rd_q) == served_time);
    stat.any_data   = found;
    stat.past_end   = $signed(window_end) < $signed(best_time);
    stat.scan_last  = (scan_idx == LIW'(LANES - 1));
    stat.out_free   = out_free;
    for (int i = 0; i < LANES; i++) begin
      if (lane_fill[i] == '0 && !lane_closed[i]) stat.open_empty = 1'b1;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      window_start <= '0;
      window_end   <= 64'h7FFF_FFFF_FFFF_FFFF;
      time_select  <= TS_SYSTEM;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_START: window_start <= cfg_data;
        CFG_WINDOW_END:   window_end   <= cfg_data;
        CFG_TIME_SELECT:  time_select  <= time_sel_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  // record store
  always_ff @(posedge clk) begin
    if (cmd.push && push_ok) begin
      mem[wr_addr] <= in_rec;
    end
    if (cmd.rd_served || cmd.rd_scan) begin
      rd_q <= mem[rd_addr];
    end
  end

  // lane bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANES; i++) begin
        lane_head[i] <= '0;
        lane_fill[i] <= '0;
      end
      lane_closed  <= '0;
      done         <= 1'b0;
      served_valid <= 1'b0;
      served_lane  <= '0;
      served_time  <= '0;
    end else begin
      if (cmd.push && push_ok) begin
        lane_fill[push_lane] <= lane_fill[push_lane] + FW'(1);
      end
      if (cmd.close && lane_ok) begin
        lane_closed[push_lane] <= 1'b1;
      end
      if (cmd.set_done) begin
        done <= 1'b1;
      end
      if (cmd.emit) begin
        lane_fill[best_lane] <= lane_fill[best_lane] - FW'(1);
        if (lane_head[best_lane] == HW'(LANE_DEPTH - 1)) begin
          lane_head[best_lane] <= '0;
        end else begin
          lane_head[best_lane] <= lane_head[best_lane] + HW'(1);
        end
        served_valid <= 1'b1;
        served_lane  <= best_lane;
        served_time  <= best_time;
      end
    end
  end

  // head scan, one lane per read
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      found    <= 1'b0;
    end else begin
      if (cmd.scan_clr) begin
        scan_idx <= '0;
        found    <= 1'b0;
      end else begin
        if (cmd.scan_next) scan_idx <= scan_idx + LIW'(1);
        if (cmd.scan_cmp && lane_fill[scan_idx] != '0) found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_pref) begin
      best_rec  <= rd_q;
      best_lane <= served_lane;
    end else if (cmd.scan_cmp && lane_fill[scan_idx] != '0
        && (!found || $signed(pick_time(time_select, rd_q)) < $signed(best_time))) begin
      best_rec  <= rd_q;
      best_lane <= scan_idx;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.load_res) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status   <= ST_RECORD;
      out_lane <= 3'(best_lane);
      out_rec  <= best_rec;
    end else if (cmd.load_res) begin
      status   <= cmd.res_kind;
      out_lane <= '0;
      out_rec  <= '0;
    end
  end

endmodule

### sv/timestamp_stream_merger.sv
`timescale 1ns / 1ps
// timestamp stream merger top level: controller, datapath, port glue
// depends on tsm_pkg, tsm_ctrl, tsm_datapath and timestamp_stream_merger_defines.svh
//
// merges up to LANES time-sorted lanes of records into one time-ordered stream.
// a push (opcode 0) or close (opcode 1) answers with an ack item; corrupt
// records and records before window_start are dropped at push.
// a pop (opcode 2) prefers the next record of the lane served last when it has
// the same selected time; otherwise all lane heads are scanned through the single
// read port of the record store, each lane read and then compared, lowest lane
// winning a tie. a pop on a done stream answers done directly; a preference hit
// reads the served lane's head, checks it and emits, and a miss runs the scan.
// one item is in work at a time; a new item is accepted when the block is
// idle and its output register is free or being taken, so a held result stalls
// the input. a pop without a preference hit answers wait while any open lane is
// empty, and done (sticky) once all lanes are closed and empty or the earliest
// head lies past window_end. no clearing pass.
module timestamp_stream_merger import tsm_pkg::*; #(
  parameter int LANES      = 8,
  parameter int LANE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  // input items
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic [2:0]         lane,
  input  logic signed [63:0] system_stamp,
  input  logic signed [63:0] plant_stamp,
  input  logic signed [63:0] local_stamp,
  input  logic [63:0]        sample_value,
  input  logic [31:0]        sample_flags,
  input  logic               corrupt,
  // result items
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [2:0]         out_lane,
  output logic signed [63:0] out_system_stamp,
  output logic signed [63:0] out_plant_stamp,
  output logic signed [63:0] out_local_stamp,
  output logic [63:0]        out_value,
  output logic [31:0]        out_flags
);

`include "timestamp_stream_merger_defines.svh"

  cmd_t    cmd;
  stat_t   stat;
  logic    idle;
  logic    in_accept;
  rec_t    in_rec;
  rec_t    out_rec;
  result_t status_q;

  // config is always taken; the user must write it only while the block is idle, the block does not enforce this
  assign cfg_ready = 1'b1;

  // accept only when idle and the result register can take the ack
  assign in_stall  = !idle || (out_valid && out_stall);
  assign in_accept = in_valid && !in_stall;

  assign in_rec.sys_stamp   = system_stamp;
  assign in_rec.plant_stamp = plant_stamp;
  assign in_rec.loc_stamp   = local_stamp;
  assign in_rec.value       = sample_value;
  assign in_rec.flags       = sample_flags;

  tsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .opcode    (opcode_t'(opcode)),
    .stat      (stat),
    .idle      (idle),
    .cmd       (cmd)
  );

  tsm_datapath #(
    .LANES      (LANES),
    .LANE_DEPTH (LANE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index_t'(cfg_index)),
    .cfg_data  (cfg_data),
    .lane      (lane),
    .in_rec    (in_rec),
    .corrupt   (corrupt),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .status    (status_q),
    .out_lane  (out_lane),
    .out_rec   (out_rec)
  );

  assign status           = status_q;
  assign out_system_stamp = out_rec.sys_stamp;
  assign out_plant_stamp  = out_rec.plant_stamp;
  assign out_local_stamp  = out_rec.loc_stamp;
  assign out_value        = out_rec.value;
  assign out_flags        = out_rec.flags;

  // an accepted item never lands on a stalled result
  `TSM_ASSERT_NOW(a_no_overrun, in_accept, !(out_valid && out_stall), "item accepted over a held result")

  // push, close and unused opcodes are acknowledged in the next cycle
  `TSM_ASSERT_NEXT(a_ack_next, in_accept && opcode != OP_POP, out_valid && status == ST_ACK, "missing ack")

  // non-record results carry zero fields
  `TSM_ASSERT_NOW(a_zero_fields, out_valid && status != ST_RECORD, out_system_stamp == '0 && out_lane == '0, "nonzero fields on non-record result")

endmodule
